>>> rtl/core/plc_pkg.sv
// Shared types, constants and microcode store for the PI + lead controller.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package plc_pkg;

   localparam int DATA_W    = 32;
   localparam int ACC_W     = 36;   // holds a sum of three 32-bit terms plus a 2*pi step
   localparam int PROD_W    = 2 * DATA_W;
   localparam int STEP_W    = 6;
   localparam int CSR_IDX_W = 3;

   localparam int DEF_CONTROLLER_KIND = 3;
   localparam int DEF_ANGLE_MODE      = 0;
   localparam int DEF_FRAC_BITS       = 14;

   // pi, 2*pi and 180/pi in Q30
   localparam longint PI_Q30     = 64'sd3373259426;
   localparam longint TWO_PI_Q30 = 64'sd6746518852;
   localparam longint DEG_Q30    = 64'sd61520874788;

   localparam logic signed [DATA_W-1:0] LIMIT_HI_RST = 32'sd1638383616;
   localparam logic signed [DATA_W-1:0] LIMIT_LO_RST = -32'sd1638383616;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN      = 3'd0,
      CSR_LEAD_POLE      = 3'd1,
      CSR_LEAD_ZERO_GAIN = 3'd2,
      CSR_INT_GAIN       = 3'd3,
      CSR_INT_MAX        = 3'd4,
      CSR_INT_MIN        = 3'd5,
      CSR_OUT_MAX        = 3'd6,
      CSR_OUT_MIN        = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic                     en;
      csr_idx_type              index;
      logic signed [DATA_W-1:0] data;
   } csr_wr_type;

   // multiplier operand selects
   typedef enum logic [2:0] {
      MA_POLE, MA_ZERO, MA_B1, MA_KP, MA_IG, MA_RES
   } mul_a_type;

   typedef enum logic [2:0] {
      MB_LOUT, MB_MEAS, MB_LIN, MB_ERR, MB_IIN, MB_P, MB_DEG
   } mul_b_type;

   typedef enum logic [2:0] {
      AO_HOLD, AO_LOAD, AO_ADD, AO_SUB, AO_WRAP, AO_CLAMP_INT, AO_CLAMP_OUT
   } acc_op_type;

   typedef enum logic [3:0] {
      AS_ONE, AS_POLE, AS_ZERO, AS_QM, AS_TGT, AS_LOUT, AS_INTEG, AS_P, AS_SCALED
   } acc_src_type;

   // register writes of the accumulator take its saturated value
   typedef enum logic [3:0] {
      WR_NONE, WR_B1, WR_LEAD, WR_BYPASS, WR_ERR, WR_P, WR_INTEG, WR_NOINT, WR_RES
   } wr_dst_type;

   typedef enum logic [1:0] {
      JMP_NONE, JMP_ALWAYS, JMP_NOLEAD, JMP_NOINT
   } jmp_type;

   typedef struct packed {
      mul_a_type          mul_a;
      mul_b_type          mul_b;
      acc_op_type         acc_op;
      acc_src_type        acc_src;
      wr_dst_type         wr_dst;
      jmp_type            jmp;
      logic [STEP_W-1:0]  dest;
      logic               done;
   } plc_ctrl_type;

   localparam plc_ctrl_type CTRL_NOP = '{
      mul_a: MA_POLE, mul_b: MB_LOUT, acc_op: AO_HOLD, acc_src: AS_ONE,
      wr_dst: WR_NONE, jmp: JMP_NONE, dest: '0, done: 1'b0
   };

   localparam logic [STEP_W-1:0] STEP_BYPASS = 6'd9;
   localparam logic [STEP_W-1:0] STEP_ERR    = 6'd10;
   localparam logic [STEP_W-1:0] STEP_NOINT  = 6'd24;
   localparam logic [STEP_W-1:0] STEP_OUT    = 6'd25;
   localparam logic [STEP_W-1:0] STEP_LAST   = 6'd32;

   // Products pass through the product register and then the rounded-product register before use.
   function automatic plc_ctrl_type plc_ucode(input logic [STEP_W-1:0] addr);
      plc_ctrl_type c;
      c = CTRL_NOP;
      case (addr)
         // lead: b1 = 1 - pole - b0
         6'd0: begin
            c.acc_op = AO_LOAD; c.acc_src = AS_ONE;
            c.jmp = JMP_NOLEAD; c.dest = STEP_BYPASS;
         end
         6'd1: begin c.acc_op = AO_SUB; c.acc_src = AS_POLE; end
         6'd2: begin c.acc_op = AO_SUB; c.acc_src = AS_ZERO; end
         6'd3: begin c.wr_dst = WR_B1; c.mul_a = MA_POLE; c.mul_b = MB_LOUT; end
         6'd4: begin c.mul_a = MA_ZERO; c.mul_b = MB_MEAS; end
         6'd5: begin
            c.mul_a = MA_B1; c.mul_b = MB_LIN;
            c.acc_op = AO_LOAD; c.acc_src = AS_QM;
         end
         6'd6: begin c.acc_op = AO_ADD; c.acc_src = AS_QM; end
         6'd7: begin c.acc_op = AO_ADD; c.acc_src = AS_QM; end
         6'd8: begin c.wr_dst = WR_LEAD; c.jmp = JMP_ALWAYS; c.dest = STEP_ERR; end
         6'd9: begin c.wr_dst = WR_BYPASS; end
         // error and proportional term
         6'd10: begin c.acc_op = AO_LOAD; c.acc_src = AS_TGT; end
         6'd11: begin c.acc_op = AO_SUB; c.acc_src = AS_LOUT; end
         6'd12: begin c.acc_op = AO_WRAP; end
         6'd13: begin c.wr_dst = WR_ERR; end
         6'd14: begin c.mul_a = MA_KP; c.mul_b = MB_ERR; end
         6'd15: begin end
         6'd16: begin c.acc_op = AO_LOAD; c.acc_src = AS_QM; end
         6'd17: begin c.wr_dst = WR_P; c.jmp = JMP_NOINT; c.dest = STEP_NOINT; end
         // trapezoidal integrator
         6'd18: begin c.mul_a = MA_IG; c.mul_b = MB_IIN; end
         6'd19: begin
            c.mul_a = MA_IG; c.mul_b = MB_P;
            c.acc_op = AO_LOAD; c.acc_src = AS_INTEG;
         end
         6'd20: begin c.acc_op = AO_ADD; c.acc_src = AS_QM; end
         6'd21: begin c.acc_op = AO_ADD; c.acc_src = AS_QM; end
         6'd22: begin c.acc_op = AO_CLAMP_INT; end
         6'd23: begin c.wr_dst = WR_INTEG; c.jmp = JMP_ALWAYS; c.dest = STEP_OUT; end
         6'd24: begin c.wr_dst = WR_NOINT; end
         // output
         6'd25: begin c.acc_op = AO_LOAD; c.acc_src = AS_P; end
         6'd26: begin c.acc_op = AO_ADD; c.acc_src = AS_INTEG; end
         6'd27: begin c.wr_dst = WR_RES; end
         6'd28: begin c.mul_a = MA_RES; c.mul_b = MB_DEG; end
         6'd29: begin end
         6'd30: begin c.acc_op = AO_LOAD; c.acc_src = AS_SCALED; end
         6'd31: begin c.acc_op = AO_CLAMP_OUT; end
         6'd32: begin c.done = 1'b1; end
         default: begin c = CTRL_NOP; end
      endcase
      return c;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
      lo = {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
      if (v > hi) return hi[DATA_W-1:0];
      if (v < lo) return lo[DATA_W-1:0];
      return v[DATA_W-1:0];
   endfunction

   function automatic logic signed [ACC_W-1:0] sext_acc(input logic signed [DATA_W-1:0] v);
      return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/plc_if.sv
// Valid/ready channel interfaces: measurement request, result and register write.
// Depends on plc_pkg for field widths.
`default_nettype none

interface plc_req_if import plc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] measured_value;
   logic signed [DATA_W-1:0] target_value;

   modport source (output valid, measured_value, target_value, input ready);
   modport sink   (input valid, measured_value, target_value, output ready);
endinterface

interface plc_rsp_if import plc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] drive;
   logic signed [DATA_W-1:0] integral_value;

   modport source (output valid, drive, integral_value, input ready);
   modport sink   (input valid, drive, integral_value, output ready);
endinterface

interface plc_csr_if import plc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_W-1:0]     index;
   logic signed [DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/plc_datapath.sv
// Datapath of the PI + lead controller: settings, filter/integrator state,
// one shared 32x32 multiplier with rounding stage, and a 36-bit accumulator.
// Depends on plc_pkg; steered by microcode words from pi_lead_controller.
`default_nettype none

module plc_datapath import plc_pkg::*; #(
   parameter int ANGLE_MODE = DEF_ANGLE_MODE,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire csr_wr_type               csr_wr,
   input  wire logic                     item_load,
   input  wire logic signed [DATA_W-1:0] item_meas,
   input  wire logic signed [DATA_W-1:0] item_tgt,
   input  wire plc_ctrl_type             ctrl,
   output logic signed [DATA_W-1:0]      drive_val,
   output logic signed [DATA_W-1:0]      integ_val
);

   localparam longint PI_L     = (PI_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
   localparam longint TWO_PI_L =
      (TWO_PI_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
   localparam longint DEG_L    = (DEG_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);

   localparam logic signed [ACC_W-1:0]  PI_C     = PI_L[ACC_W-1:0];
   localparam logic signed [ACC_W-1:0]  TWO_PI_C = TWO_PI_L[ACC_W-1:0];
   localparam logic signed [DATA_W-1:0] DEG_C    = DEG_L[DATA_W-1:0];
   localparam logic signed [ACC_W-1:0]  ONE_C    = ACC_W'(64'sd1 <<< FRAC_BITS);
   localparam logic signed [PROD_W-1:0] HALF_C   = PROD_W'(64'sd1 <<< (FRAC_BITS - 1));

   // settings
   logic signed [DATA_W-1:0] kp_ff, pole_ff, zero_ff, ig_ff;
   logic signed [DATA_W-1:0] int_max_ff, int_min_ff, out_max_ff, out_min_ff;

   // loop state
   logic signed [DATA_W-1:0] lout_ff, lin_ff, integ_ff, iin_ff;

   // working registers
   logic signed [DATA_W-1:0] meas_ff, tgt_ff, b1_ff, err_ff, p_ff, res_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [DATA_W-1:0] qm_ff, qm_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   logic signed [DATA_W-1:0] mul_a, mul_b, acc_opnd, acc_sat, clamp_val;
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [PROD_W-1:0] prod_shr;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff      <= '0;
         pole_ff    <= '0;
         zero_ff    <= '0;
         ig_ff      <= '0;
         int_max_ff <= LIMIT_HI_RST;
         int_min_ff <= LIMIT_LO_RST;
         out_max_ff <= LIMIT_HI_RST;
         out_min_ff <= LIMIT_LO_RST;
      end else if (csr_wr.en) begin
         unique case (csr_wr.index)
            CSR_PROP_GAIN:      kp_ff      <= csr_wr.data;
            CSR_LEAD_POLE:      pole_ff    <= csr_wr.data;
            CSR_LEAD_ZERO_GAIN: zero_ff    <= csr_wr.data;
            CSR_INT_GAIN:       ig_ff      <= csr_wr.data;
            CSR_INT_MAX:        int_max_ff <= csr_wr.data;
            CSR_INT_MIN:        int_min_ff <= csr_wr.data;
            CSR_OUT_MAX:        out_max_ff <= csr_wr.data;
            CSR_OUT_MIN:        out_min_ff <= csr_wr.data;
            default: begin end
         endcase
      end
   end

   always_comb begin
      case (ctrl.mul_a)
         MA_POLE: mul_a = pole_ff;
         MA_ZERO: mul_a = zero_ff;
         MA_B1:   mul_a = b1_ff;
         MA_KP:   mul_a = kp_ff;
         MA_IG:   mul_a = ig_ff;
         MA_RES:  mul_a = res_ff;
         default: mul_a = '0;
      endcase
      case (ctrl.mul_b)
         MB_LOUT: mul_b = lout_ff;
         MB_MEAS: mul_b = meas_ff;
         MB_LIN:  mul_b = lin_ff;
         MB_ERR:  mul_b = err_ff;
         MB_IIN:  mul_b = iin_ff;
         MB_P:    mul_b = p_ff;
         MB_DEG:  mul_b = DEG_C;
         default: mul_b = '0;
      endcase
   end

   // product, then round half up and saturate in the next stage
   assign prod_in  = mul_a * mul_b;
   assign prod_rnd = prod_ff + HALF_C;
   assign prod_shr = prod_rnd >>> FRAC_BITS;
   always_comb begin
      if (prod_shr > PROD_W'(64'sd2147483647))
         qm_in = {1'b0, {(DATA_W-1){1'b1}}};
      else if (prod_shr < -PROD_W'(64'sd2147483648))
         qm_in = {1'b1, {(DATA_W-1){1'b0}}};
      else
         qm_in = prod_shr[DATA_W-1:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      qm_ff   <= qm_in;
   end

   always_comb begin
      case (ctrl.acc_src)
         AS_ONE:    acc_opnd = ONE_C[DATA_W-1:0];
         AS_POLE:   acc_opnd = pole_ff;
         AS_ZERO:   acc_opnd = zero_ff;
         AS_QM:     acc_opnd = qm_ff;
         AS_TGT:    acc_opnd = tgt_ff;
         AS_LOUT:   acc_opnd = lout_ff;
         AS_INTEG:  acc_opnd = integ_ff;
         AS_P:      acc_opnd = p_ff;
         AS_SCALED: acc_opnd = (ANGLE_MODE != 0) ? qm_ff : res_ff;
         default:   acc_opnd = '0;
      endcase
   end

   assign acc_sat = sat32(acc_ff);

   // integrator clamp tests the upper limit first, output clamp the lower
   always_comb begin
      clamp_val = acc_sat;
      if (ctrl.acc_op == AO_CLAMP_INT) begin
         if (acc_sat > int_max_ff)      clamp_val = int_max_ff;
         else if (acc_sat < int_min_ff) clamp_val = int_min_ff;
      end else begin
         if (acc_sat < out_min_ff)      clamp_val = out_min_ff;
         else if (acc_sat > out_max_ff) clamp_val = out_max_ff;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      case (ctrl.acc_op)
         AO_HOLD: acc_in = acc_ff;
         AO_LOAD: acc_in = sext_acc(acc_opnd);
         AO_ADD:  acc_in = acc_ff + sext_acc(acc_opnd);
         AO_SUB:  acc_in = acc_ff - sext_acc(acc_opnd);
         AO_WRAP: begin
            // single 2*pi correction
            if (ANGLE_MODE != 0) begin
               if (acc_ff > PI_C)       acc_in = acc_ff - TWO_PI_C;
               else if (acc_ff < -PI_C) acc_in = acc_ff + TWO_PI_C;
            end
         end
         AO_CLAMP_INT, AO_CLAMP_OUT: acc_in = sext_acc(clamp_val);
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (item_load) begin
         meas_ff <= item_meas;
         tgt_ff  <= item_tgt;
      end
      case (ctrl.wr_dst)
         WR_B1:  b1_ff  <= acc_sat;
         WR_ERR: err_ff <= acc_sat;
         WR_P:   p_ff   <= acc_sat;
         WR_RES: res_ff <= acc_sat;
         default: begin end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lout_ff  <= '0;
         lin_ff   <= '0;
         integ_ff <= '0;
         iin_ff   <= '0;
      end else begin
         case (ctrl.wr_dst)
            WR_LEAD: begin
               lout_ff <= acc_sat;
               lin_ff  <= meas_ff;
            end
            WR_BYPASS: lout_ff <= meas_ff;
            WR_INTEG: begin
               integ_ff <= acc_sat;
               iin_ff   <= p_ff;
            end
            WR_NOINT: integ_ff <= '0;
            default: begin end
         endcase
      end
   end

   assign drive_val = acc_sat;
   assign integ_val = integ_ff;

endmodule

`default_nettype wire

>>> rtl/core/pi_lead_controller.sv
// PI controller with Tustin lead compensator on the measurement, Q(32-F).F.
//
// Channels: req_chan takes one tick (measured_value, target_value); rsp_chan
// returns drive and integral_value for that tick; csr_chan writes one of the
// eight settings (index 0..7), always ready, and is to be used while idle.
// A step counter walks a microcode store of 33 words; each word steers the
// shared multiplier, the accumulator and the register writes in plc_datapath.
// The shared multiplier has a two-stage product/rounding path: every product
// passes through both stages before the accumulator can use it.
// One tick is processed at a time; a new request is taken in the cycle after
// the previous result has been loaded into the output register, even while
// that result still waits for the receiver.
// If the receiver stalls and a second result is ready, the sequencer holds on
// its final step until the output register frees up.
// Reset (synchronous, active high) clears the filter and integrator memory,
// the settings to their defaults and empties the output register.
`default_nettype none

module pi_lead_controller import plc_pkg::*; #(
   parameter int CONTROLLER_KIND = DEF_CONTROLLER_KIND,
   parameter int ANGLE_MODE      = DEF_ANGLE_MODE,
   parameter int FRAC_BITS       = DEF_FRAC_BITS
) (
   input wire logic    clock,
   input wire logic    reset,
   plc_req_if.sink     req_chan,
   plc_rsp_if.source   rsp_chan,
   plc_csr_if.sink     csr_chan
);

   localparam bit LEAD_EN = (CONTROLLER_KIND & 2) != 0;
   localparam bit INT_EN  = (CONTROLLER_KIND & 1) != 0;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type                state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] drive_ff, integral_ff;

   plc_ctrl_type             ucode, ctrl;
   csr_wr_type               csr_wr;
   logic                     req_xfer, out_free, out_load, jump_taken;
   logic signed [DATA_W-1:0] drive_val, integ_val;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign csr_wr.en    = csr_chan.valid;
   assign csr_wr.index = csr_idx_type'(csr_chan.index);
   assign csr_wr.data  = csr_chan.data;

   assign ucode = plc_ucode(step_ff);
   assign ctrl  = (state_ff == ST_RUN) ? ucode : CTRL_NOP;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign out_load = (state_ff == ST_RUN) && ucode.done && out_free;

   always_comb begin
      case (ucode.jmp)
         JMP_ALWAYS: jump_taken = 1'b1;
         JMP_NOLEAD: jump_taken = !LEAD_EN;
         JMP_NOINT:  jump_taken = !INT_EN;
         default:    jump_taken = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            if (ucode.done) begin
               if (out_free) state_in = ST_IDLE;
            end else if (jump_taken) begin
               step_in = ucode.dest;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load)           rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         drive_ff    <= drive_val;
         integral_ff <= integ_val;
      end
   end

   plc_datapath #(
      .ANGLE_MODE (ANGLE_MODE),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr    (csr_wr),
      .item_load (req_xfer),
      .item_meas (req_chan.measured_value),
      .item_tgt  (req_chan.target_value),
      .ctrl      (ctrl),
      .drive_val (drive_val),
      .integ_val (integ_val)
   );

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.drive          = drive_ff;
   assign rsp_chan.integral_value = integral_ff;

   // a request transfer always starts the program at its first step
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_RUN) && (step_ff == '0))
      else $error("sequencer did not start at step zero");

   // the step counter stays inside the program
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (step_ff <= STEP_LAST))
      else $error("step counter beyond end of program");

   // a new result only appears after the final step of a run
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RUN) && $past(ucode.done))
      else $error("result raised outside the final step");

   // with the integrator disabled the reported integral is zero
   a_noint: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !INT_EN) |-> (integral_ff == '0))
      else $error("integral reported with integrator disabled");

endmodule

`default_nettype wire
